FILE: rtl/core/rrtr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrtr_pkg;

  // Fixed field widths of the item and result channels.
  localparam int OP_W  = 2;
  localparam int ID_W  = 4;
  localparam int ST_W  = 2;
  localparam int LEN_W = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADMIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT   = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [ST_W-1:0] ST_ABSENT  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // register the accepted item
    logic rd_head_pred; // read the predecessor of the head (the tail)
    logic rd_id_links;  // read both links of the item's slot
    logic rd_cur_succ;  // read the successor of the current slot
    logic wr_self;      // first entry: link the slot to itself
    logic wr_new;       // link the new slot between tail and head
    logic wr_splice;    // point tail and head at the new slot
    logic wr_unlink;    // bridge the neighbors of a removed slot
    logic finish;       // update pointers and load the result
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            id_ok;
    logic            hit;
    logic            empty;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/rrtr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rrtr_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rrtr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rrtr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  output      logic              out_valid,
  input  wire logic              out_ready,
  input  wire rrtr_pkg::dp_stat_t stat,
  output      rrtr_pkg::ctl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_ADM_W1 = 3'd2;
  localparam logic [2:0] S_ADM_W2 = 3'd3;
  localparam logic [2:0] S_REM_W  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Sequencer: decode the operation, then walk the link reads and writes it needs.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FIN;
        case (stat.op)
          rrtr_pkg::OP_ADMIT: begin
            if (stat.id_ok && !stat.hit) begin
              if (stat.empty) begin
                cmd.wr_self = 1'b1;
              end else begin
                cmd.rd_head_pred = 1'b1;
                state_nxt        = S_ADM_W1;
              end
            end
          end
          rrtr_pkg::OP_REMOVE: begin
            if (stat.id_ok && stat.hit) begin
              cmd.rd_id_links = 1'b1;
              state_nxt       = S_REM_W;
            end
          end
          rrtr_pkg::OP_NEXT: begin
            if (!stat.empty) begin
              cmd.rd_cur_succ = 1'b1;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_ADM_W1: begin
        cmd.wr_new = 1'b1;
        state_nxt  = S_ADM_W2;
      end
      S_ADM_W2: begin
        cmd.wr_splice = 1'b1;
        state_nxt     = S_FIN;
      end
      S_REM_W: begin
        cmd.wr_unlink = 1'b1;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The result register is full from the finish step until its transfer.
  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rrtr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rrtr_dp #(
  parameter int MAX_THREADS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [rrtr_pkg::OP_W-1:0]     in_operation,
  input  wire logic [rrtr_pkg::ID_W-1:0]     in_thread_id,
  input  wire rrtr_pkg::ctl_cmd_t            cmd,
  output      rrtr_pkg::dp_stat_t            stat,
  output      logic [rrtr_pkg::ID_W-1:0]     out_served_id,
  output      logic                          out_served_valid,
  output      logic [rrtr_pkg::ST_W-1:0]     out_status,
  output      logic [rrtr_pkg::LEN_W-1:0]    out_queue_length
);

  localparam int IDX_W = $clog2(MAX_THREADS);

  // Captured item.
  logic [rrtr_pkg::OP_W-1:0] op_r;
  logic [rrtr_pkg::ID_W-1:0] id_r;

  // Ring state.
  logic [MAX_THREADS-1:0]     member_r, member_nxt;
  logic [IDX_W-1:0]           head_r, head_nxt;
  logic [IDX_W-1:0]           cur_r, cur_nxt;
  logic [rrtr_pkg::LEN_W-1:0] total_r, total_nxt;

  // Result register.
  logic [rrtr_pkg::ID_W-1:0]  served_r, served_nxt;
  logic                       sval_r, sval_nxt;
  logic [rrtr_pkg::ST_W-1:0]  status_r, status_nxt;

  logic [IDX_W-1:0] slot;
  logic             id_ok;
  logic             hit;
  logic             empty;
  logic             single;

  // Link memories.
  logic             s_we, s_re, p_we, p_re;
  logic [IDX_W-1:0] s_waddr, s_wdata, s_raddr, s_rdata;
  logic [IDX_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata;

  assign slot   = IDX_W'(id_r);
  assign id_ok  = (32'(id_r) < 32'(MAX_THREADS));
  assign hit    = id_ok && member_r[slot];
  assign empty  = (total_r == '0);
  // After a link read at the removed slot: it was the only entry.
  assign single = (s_rdata == slot);

  assign stat.op    = op_r;
  assign stat.id_ok = id_ok;
  assign stat.hit   = hit;
  assign stat.empty = empty;

  // Successor memory port selection.
  always_comb begin
    s_re    = cmd.rd_id_links || cmd.rd_cur_succ;
    s_raddr = cmd.rd_cur_succ ? cur_r : slot;
    s_we    = cmd.wr_self || cmd.wr_new || cmd.wr_splice || (cmd.wr_unlink && !single);
    s_waddr = slot;
    s_wdata = slot;
    if (cmd.wr_new) begin
      s_wdata = head_r;
    end else if (cmd.wr_splice) begin
      s_waddr = p_rdata;
    end else if (cmd.wr_unlink) begin
      s_waddr = p_rdata;
      s_wdata = s_rdata;
    end
  end

  // Predecessor memory port selection.
  always_comb begin
    p_re    = cmd.rd_head_pred || cmd.rd_id_links;
    p_raddr = cmd.rd_head_pred ? head_r : slot;
    p_we    = s_we;
    p_waddr = slot;
    p_wdata = slot;
    if (cmd.wr_new) begin
      p_wdata = p_rdata;
    end else if (cmd.wr_splice) begin
      p_waddr = head_r;
    end else if (cmd.wr_unlink) begin
      p_waddr = s_rdata;
      p_wdata = p_rdata;
    end
  end

  rrtr_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_THREADS)
  ) u_succ_ram (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .re   (s_re),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  rrtr_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_THREADS)
  ) u_pred_ram (
    .clk  (clk),
    .we   (p_we),
    .waddr(p_waddr),
    .wdata(p_wdata),
    .re   (p_re),
    .raddr(p_raddr),
    .rdata(p_rdata)
  );

  // Finish step: commit pointers, membership and length, and form the result.
  always_comb begin
    member_nxt = member_r;
    head_nxt   = head_r;
    cur_nxt    = cur_r;
    total_nxt  = total_r;
    served_nxt = served_r;
    sval_nxt   = sval_r;
    status_nxt = status_r;
    if (cmd.finish) begin
      served_nxt = '0;
      sval_nxt   = 1'b0;
      status_nxt = rrtr_pkg::ST_DONE;
      case (op_r)
        rrtr_pkg::OP_ADMIT: begin
          if (!id_ok) begin
            status_nxt = rrtr_pkg::ST_ABSENT;
          end else if (hit) begin
            status_nxt = rrtr_pkg::ST_PRESENT;
          end else begin
            if (empty) begin
              head_nxt = slot;
              cur_nxt  = slot;
            end
            member_nxt[slot] = 1'b1;
            total_nxt        = total_r + 1'b1;
          end
        end
        rrtr_pkg::OP_REMOVE: begin
          if (!hit) begin
            status_nxt = rrtr_pkg::ST_ABSENT;
          end else begin
            if (single) begin
              head_nxt = '0;
              cur_nxt  = '0;
            end else begin
              if (head_r == slot) begin
                head_nxt = s_rdata;
              end
              if (cur_r == slot) begin
                cur_nxt = s_rdata;
              end
            end
            member_nxt[slot] = 1'b0;
            total_nxt        = total_r - 1'b1;
          end
        end
        rrtr_pkg::OP_NEXT: begin
          if (empty) begin
            status_nxt = rrtr_pkg::ST_EMPTY;
          end else begin
            served_nxt = rrtr_pkg::ID_W'(cur_r);
            sval_nxt   = 1'b1;
            cur_nxt    = s_rdata;
          end
        end
        default: begin
          status_nxt = rrtr_pkg::ST_DONE;
        end
      endcase
    end
  end

  // Item capture and result payload need no reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_operation;
      id_r <= in_thread_id;
    end
    served_r <= served_nxt;
    sval_r   <= sval_nxt;
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      member_r <= '0;
      head_r   <= '0;
      cur_r    <= '0;
      total_r  <= '0;
    end else begin
      member_r <= member_nxt;
      head_r   <= head_nxt;
      cur_r    <= cur_nxt;
      total_r  <= total_nxt;
    end
  end

  assign out_served_id    = served_r;
  assign out_served_valid = sval_r;
  assign out_status       = status_r;
  assign out_queue_length = total_r;

endmodule

`default_nettype wire

FILE: rtl/core/round_robin_thread_ring.sv
`timescale 1ns / 1ps
`default_nettype none

// Round-robin thread scheduler kept as a circular ring of thread identifiers in
// insertion order. Each item is one operation: admit links an identifier in at the
// tail (just before the head), remove unlinks it, and next returns the current
// identifier and advances to its successor. Every result carries a status and the
// ring length afterwards. Identifiers at or above MAX_THREADS have no slot and are
// reported as not present. Successor and predecessor links live in two small RAMs
// with one write and one registered read port each; membership bits are flip-flops
// cleared at reset, so no clearing pass is needed. One item is in work at a time,
// and it holds the block from its transfer until its finish step. A rejected
// operation, a first admit or a next goes from decode straight to the finish step;
// a remove passes through an unlink write step; an admit to a non-empty ring reads
// the tail in decode and needs two write steps on the single RAM write ports.
// A finished result waits in the output register while the block is again ready;
// while it is not taken, the next item stalls in its final step.
module round_robin_thread_ring #(
  parameter int MAX_THREADS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [rrtr_pkg::OP_W-1:0]     in_operation,
  input  wire logic [rrtr_pkg::ID_W-1:0]     in_thread_id,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [rrtr_pkg::ID_W-1:0]     out_served_id,
  output      logic                          out_served_valid,
  output      logic [rrtr_pkg::ST_W-1:0]     out_status,
  output      logic [rrtr_pkg::LEN_W-1:0]    out_queue_length
);

  rrtr_pkg::ctl_cmd_t cmd;
  rrtr_pkg::dp_stat_t stat;

  rrtr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrtr_dp #(
    .MAX_THREADS(MAX_THREADS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_operation),
    .in_thread_id    (in_thread_id),
    .cmd             (cmd),
    .stat            (stat),
    .out_served_id   (out_served_id),
    .out_served_valid(out_served_valid),
    .out_status      (out_status),
    .out_queue_length(out_queue_length)
  );

endmodule

`default_nettype wire
